[design/lhbfr_pkg.sv]
// Shared types and constants for the love/hate buffer frame replacer.
package lhbfr_pkg;
  localparam int NUM_FRAMES = 64;
  localparam int FW = $clog2(NUM_FRAMES);
  localparam int CW = FW + 1;
  localparam int PAGE_W = 31;
  localparam int PIN_W = 16;

  localparam logic [1:0] OP_PIN   = 2'd0;
  localparam logic [1:0] OP_UNPIN = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;
  localparam logic [1:0] OP_FLUSH = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_UNPIN_ERR = 3'd2;
  localparam logic [2:0] ST_FREE_ERR  = 3'd3;
  localparam logic [2:0] ST_FLUSH_ERR = 3'd4;

  localparam logic [1:0] LM_NONE  = 2'd0;
  localparam logic [1:0] LM_HATED = 2'd1;
  localparam logic [1:0] LM_LOVED = 2'd2;

  typedef struct packed {
    logic [2:0]        status;
    logic [FW-1:0]     frame_index;
    logic              load_needed;
    logic              writeback_valid;
    logic [PAGE_W-1:0] writeback_page_id;
  } result_t;
endpackage

[design/lhbfr_list.sv]
// Ordered frame list in a memory with a remove/shift engine; appends are taken only while the engine is idle.
module lhbfr_list (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   rm_start,
  input  logic [lhbfr_pkg::FW-1:0] rm_frame,
  input  logic                   push,
  input  logic [lhbfr_pkg::FW-1:0] push_frame,
  input  logic                   rd_req,
  input  logic [lhbfr_pkg::FW-1:0] rd_addr,
  output logic [lhbfr_pkg::FW-1:0] rd_data,
  output logic [lhbfr_pkg::CW-1:0] count,
  output logic                   busy
);
  import lhbfr_pkg::*;

  logic [FW-1:0] mem [NUM_FRAMES];
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          found_r, found_nxt;
  logic          busy_r, busy_nxt;
  logic [1:0]    ph_r, ph_nxt;
  logic [FW-1:0] rdq_r;
  logic [FW-1:0] raddr;
  logic          mwe;
  logic [FW-1:0] maddr, mdata;

  assign count = count_r;
  assign busy  = busy_r;
  assign rd_data = rdq_r;

  // Phase 0 reads entry idx; phase 1 compares it with rm_frame or, once found, writes it one slot down.
  always_comb begin
    count_nxt = count_r;
    idx_nxt   = idx_r;
    found_nxt = found_r;
    busy_nxt  = busy_r;
    ph_nxt    = ph_r;
    raddr     = rd_addr;
    mwe       = 1'b0;
    maddr     = push_frame;
    mdata     = push_frame;
    if (rm_start) begin
      busy_nxt  = 1'b1;
      idx_nxt   = '0;
      found_nxt = 1'b0;
      ph_nxt    = 2'd0;
    end else if (busy_r) begin
      if (idx_r >= count_r) begin
        busy_nxt = 1'b0;
        if (found_r) count_nxt = count_r - CW'(1);
      end else if (ph_r == 2'd0) begin
        raddr  = idx_r[FW-1:0];
        ph_nxt = 2'd1;
      end else begin
        ph_nxt = 2'd0;
        if (found_r) begin
          mwe   = 1'b1;
          maddr = idx_r[FW-1:0] - FW'(1);
          mdata = rdq_r;
        end else if (rdq_r == rm_frame) begin
          found_nxt = 1'b1;
        end
        idx_nxt = idx_r + CW'(1);
      end
    end else if (push && count_r < CW'(NUM_FRAMES)) begin
      mwe       = 1'b1;
      maddr     = count_r[FW-1:0];
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (mwe) mem[maddr] <= mdata;
    if (rd_req || busy_r) rdq_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      idx_r   <= '0;
      found_r <= 1'b0;
      busy_r  <= 1'b0;
      ph_r    <= 2'd0;
    end else begin
      count_r <= count_nxt;
      idx_r   <= idx_nxt;
      found_r <= found_nxt;
      busy_r  <= busy_nxt;
      ph_r    <= ph_nxt;
    end
  end
endmodule

[design/love_hate_buffer_frame_replacer_top.sv]
// Top level of the love/hate buffer frame replacer: sequencer and frame table.
// One request at a time. A request scans the frame table through a single
// comparator, reading each entry and then comparing it, then reads the chosen
// frame, decides and applies its update. Taking a frame off the hated or loved
// list walks that list in its remove/shift engine. An eviction first finds and
// reads the victim. A pin miss served from the free pointer walks forward one
// frame per cycle to the next free frame. The result is held in an output
// register until taken; the next request is accepted once it is delivered.
module love_hate_buffer_frame_replacer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_op,
  input  logic [lhbfr_pkg::PAGE_W-1:0]  in_page_id,
  input  logic                          in_dirty_flag,
  input  logic                          in_hate_flag,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [2:0]                    out_status,
  output logic [lhbfr_pkg::FW-1:0]      out_frame_index,
  output logic                          out_load_needed,
  output logic                          out_writeback_valid,
  output logic [lhbfr_pkg::PAGE_W-1:0]  out_writeback_page_id
);
  import lhbfr_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SCAN  = 4'd1;
  localparam logic [3:0] S_SRD   = 4'd2;
  localparam logic [3:0] S_DEC   = 4'd3;
  localparam logic [3:0] S_VRD   = 4'd4;
  localparam logic [3:0] S_VGET  = 4'd5;
  localparam logic [3:0] S_RMW   = 4'd6;
  localparam logic [3:0] S_FFREE = 4'd7;
  localparam logic [3:0] S_APPLY = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;
  localparam logic [3:0] S_FRD   = 4'd10;
  localparam logic [3:0] S_VFRD  = 4'd11;
  localparam logic [3:0] S_VCHK  = 4'd12;
  localparam logic [3:0] S_RMS   = 4'd13;

  // Frame table
  logic [PAGE_W-1:0] page_mem [NUM_FRAMES];
  logic [PIN_W-1:0]  pin_mem  [NUM_FRAMES];
  logic              dirty_mem[NUM_FRAMES];
  logic              hate_mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r;

  logic [3:0]        st_r;
  logic [1:0]        op_r;
  logic [PAGE_W-1:0] pg_r;
  logic              df_r, hf_r;
  logic [CW-1:0]     ptr_r;
  logic              hit_r;
  logic [FW-1:0]     f_r;
  logic [CW-1:0]     ff_r;
  logic [PAGE_W-1:0] pq_r;
  logic [PIN_W-1:0]  nq_r;
  logic              dq_r, hq_r;
  logic              take_free_r;
  result_t           res_r;

  logic [FW-1:0] rd_a;
  logic          h_rm, l_rm, h_push, l_push, h_rd, l_rd;
  logic [FW-1:0] h_q, l_q;
  logic [CW-1:0] h_cnt, l_cnt;
  logic          h_busy, l_busy;

  logic              page_we, pin_we, dirty_we, hate_we;
  logic [PAGE_W-1:0] page_wd;
  logic [PIN_W-1:0]  pin_wd;
  logic              dirty_wd, hate_wd;

  lhbfr_list u_hated (.clk, .rst_n, .rm_start(h_rm), .rm_frame(f_r),
    .push(h_push), .push_frame(f_r), .rd_req(h_rd), .rd_addr(rd_a),
    .rd_data(h_q), .count(h_cnt), .busy(h_busy));
  lhbfr_list u_loved (.clk, .rst_n, .rm_start(l_rm), .rm_frame(f_r),
    .push(l_push), .push_frame(f_r), .rd_req(l_rd), .rd_addr(rd_a),
    .rd_data(l_q), .count(l_cnt), .busy(l_busy));

  assign in_stall = (st_r != S_IDLE);
  assign out_valid = (st_r == S_OUT);
  assign out_status = res_r.status;
  assign out_frame_index = res_r.frame_index;
  assign out_load_needed = res_r.load_needed;
  assign out_writeback_valid = res_r.writeback_valid;
  assign out_writeback_page_id = res_r.writeback_page_id;

  // Read port of the frame table: scan pointer or chosen frame
  logic [FW-1:0] tab_a;
  assign tab_a = (st_r == S_SCAN) ? ptr_r[FW-1:0] : f_r;
  // Victim address: newest hated entry, else oldest loved entry
  assign rd_a = (h_cnt != '0) ? FW'(h_cnt - CW'(1)) : '0;

  logic [PIN_W-1:0] nq_dec;
  assign nq_dec = nq_r - PIN_W'(1);

  // List control: remove the chosen frame, append on the last unpin
  always_comb begin
    h_rd   = (st_r == S_VRD) && (h_cnt != '0);
    l_rd   = (st_r == S_VRD) && (h_cnt == '0);
    h_rm   = (st_r == S_RMS) && hq_r;
    l_rm   = (st_r == S_RMS) && !hq_r;
    h_push = (st_r == S_APPLY) && (op_r == OP_UNPIN) && (nq_dec == '0) && hq_r && hf_r;
    l_push = (st_r == S_APPLY) && (op_r == OP_UNPIN) && (nq_dec == '0) && !(hq_r && hf_r);
  end

  // Table update for the request being applied
  always_comb begin
    page_we  = 1'b0;
    pin_we   = 1'b0;
    dirty_we = 1'b0;
    hate_we  = 1'b0;
    page_wd  = pg_r;
    pin_wd   = PIN_W'(1);
    dirty_wd = 1'b0;
    hate_wd  = 1'b1;
    if (st_r == S_APPLY) begin
      unique case (op_r)
        OP_PIN: if (hit_r) begin
          pin_we = 1'b1;
          pin_wd = (&nq_r) ? nq_r : nq_r + PIN_W'(1);
        end else begin
          page_we  = 1'b1;
          pin_we   = 1'b1;
          dirty_we = 1'b1;
          hate_we  = 1'b1;
        end
        OP_UNPIN: begin
          pin_we   = 1'b1;
          pin_wd   = nq_dec;
          dirty_we = 1'b1;
          dirty_wd = dq_r | df_r;
          hate_we  = 1'b1;
          hate_wd  = hq_r & hf_r;
        end
        OP_FLUSH: dirty_we = 1'b1;
        default: ;
      endcase
    end
  end

  // Frame table write and registered read
  always_ff @(posedge clk) begin
    if (page_we)  page_mem[f_r]  <= page_wd;
    if (pin_we)   pin_mem[f_r]   <= pin_wd;
    if (dirty_we) dirty_mem[f_r] <= dirty_wd;
    if (hate_we)  hate_mem[f_r]  <= hate_wd;
    pq_r <= page_mem[tab_a];
    nq_r <= pin_mem[tab_a];
    dq_r <= dirty_mem[tab_a];
    hq_r <= hate_mem[tab_a];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_IDLE;
      valid_r <= '0;
      ff_r    <= '0;
    end else begin
      unique case (st_r)
        S_IDLE: if (in_valid) begin
          op_r <= in_op; pg_r <= in_page_id; df_r <= in_dirty_flag;
          hf_r <= in_hate_flag; ptr_r <= '0; hit_r <= 1'b0; f_r <= '0;
          st_r <= S_SCAN;
        end
        // each table entry is read in S_SCAN, then compared in S_SRD
        S_SCAN: st_r <= S_SRD;
        S_SRD: begin
          if (!hit_r && valid_r[ptr_r[FW-1:0]] && pq_r == pg_r) begin
            hit_r <= 1'b1; f_r <= ptr_r[FW-1:0];
          end
          if (ptr_r == CW'(NUM_FRAMES - 1)) st_r <= S_FRD;
          else begin ptr_r <= ptr_r + CW'(1); st_r <= S_SCAN; end
        end
        // fetch the matching frame's entry
        S_FRD: st_r <= S_DEC;
        S_DEC: begin
          res_r <= '0;
          take_free_r <= 1'b0;
          unique case (op_r)
            OP_PIN: if (hit_r) st_r <= (nq_r == '0) ? S_RMS : S_APPLY;
              else if (ff_r < CW'(NUM_FRAMES)) begin
                f_r <= ff_r[FW-1:0]; take_free_r <= 1'b1; st_r <= S_APPLY;
              end else if (h_cnt != '0 || l_cnt != '0) begin
                st_r <= S_VRD;
              end else begin
                res_r.status <= ST_FULL; st_r <= S_OUT;
              end
            OP_UNPIN: if (!hit_r || nq_r == '0) begin
                res_r.status <= ST_UNPIN_ERR; st_r <= S_OUT;
              end else st_r <= S_APPLY;
            OP_FREE: if (!hit_r || nq_r != '0) begin
                res_r.status <= ST_FREE_ERR; st_r <= S_OUT;
              end else st_r <= S_RMS;
            default: if (!hit_r) begin
                res_r.status <= ST_FLUSH_ERR; st_r <= S_OUT;
              end else st_r <= S_APPLY;
          endcase
        end
        // pick the victim from a list, then read its entry
        S_VRD: st_r <= S_VGET;
        S_VGET: begin
          f_r <= (h_cnt != '0) ? h_q : l_q;
          st_r <= S_VFRD;
        end
        S_VFRD: st_r <= S_VCHK;
        S_VCHK: begin
          if (dq_r) begin
            res_r.writeback_valid <= 1'b1;
            res_r.writeback_page_id <= pq_r;
          end
          st_r <= S_RMS;
        end
        // take the frame off its list and wait for the walk to finish
        S_RMS: st_r <= S_RMW;
        S_RMW: if (!h_busy && !l_busy) st_r <= S_APPLY;
        S_APPLY: begin
          res_r.frame_index <= f_r;
          st_r <= S_OUT;
          unique case (op_r)
            OP_PIN: if (!hit_r) begin
              valid_r[f_r] <= 1'b1;
              res_r.load_needed <= 1'b1;
              if (take_free_r) begin
                ff_r <= ff_r + CW'(1);
                st_r <= S_FFREE;
              end
            end
            OP_FREE: begin
              valid_r[f_r] <= 1'b0;
              if (ff_r > {1'b0, f_r}) ff_r <= {1'b0, f_r};
            end
            OP_FLUSH: if (dq_r) begin
              res_r.writeback_valid <= 1'b1;
              res_r.writeback_page_id <= pq_r;
            end
            default: ;
          endcase
        end
        // advance the free pointer past frames in use
        S_FFREE: begin
          if (ff_r < CW'(NUM_FRAMES) && valid_r[ff_r[FW-1:0]]) ff_r <= ff_r + CW'(1);
          else st_r <= S_OUT;
        end
        S_OUT: if (!out_stall) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

[sim/testbench.sv]
// Self-checking testbench for the love/hate buffer frame replacer top level.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lhbfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PIN_SAT = 65535;

  typedef struct packed {
    logic [1:0]        op;
    logic [PAGE_W-1:0] page;
    logic              dflag;
    logic              hflag;
  } req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_op = '0;
  logic [PAGE_W-1:0] in_page_id = '0;
  logic in_dirty_flag = 1'b0;
  logic in_hate_flag = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic [FW-1:0] out_frame_index;
  logic out_load_needed;
  logic out_writeback_valid;
  logic [PAGE_W-1:0] out_writeback_page_id;

  love_hate_buffer_frame_replacer_top DUT (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow frame table
  bit            fr_valid [NUM_FRAMES];
  bit [PAGE_W-1:0] fr_page [NUM_FRAMES];
  int            fr_pins [NUM_FRAMES];
  bit            fr_dirty [NUM_FRAMES];
  bit            fr_hate [NUM_FRAMES];
  logic [1:0]    fr_list [NUM_FRAMES];
  int            hated_q[$];
  int            loved_q[$];
  int            free_ptr;

  req_t    pending_reqs[$];
  result_t expected_results[$];
  int      sent_count, got_count, mismatch_count;
  int      idle_cycles;
  bit      hold_rx, hold_tx;
  int      op_seen [4];

  function automatic int find_frame(logic [PAGE_W-1:0] page);
    for (int i = 0; i < NUM_FRAMES; i++)
      if (fr_valid[i] && fr_page[i] == page) return i;
    return -1;
  endfunction

  function automatic void relist(int f, logic [1:0] to);
    if (fr_list[f] == LM_HATED) begin
      foreach (hated_q[i]) if (hated_q[i] == f) begin hated_q.delete(i); break; end
    end else if (fr_list[f] == LM_LOVED) begin
      foreach (loved_q[i]) if (loved_q[i] == f) begin loved_q.delete(i); break; end
    end
    if (to == LM_HATED) hated_q.push_back(f);
    else if (to == LM_LOVED) loved_q.push_back(f);
    fr_list[f] = to;
  endfunction

  // Apply one request to the shadow table and return the expected result
  function automatic result_t replace_frame(req_t r);
    result_t res;
    int f, v;
    bit got;
    res = '0;
    f = find_frame(r.page);
    case (r.op)
      OP_PIN: begin
        if (f >= 0) begin
          if (fr_pins[f] == 0) relist(f, LM_NONE);
          if (fr_pins[f] < PIN_SAT) fr_pins[f]++;
          res.frame_index = FW'(f);
        end else begin
          got = 1'b1;
          v = 0;
          if (free_ptr < NUM_FRAMES) begin
            v = free_ptr;
            free_ptr++;
            while (free_ptr < NUM_FRAMES && fr_valid[free_ptr]) free_ptr++;
          end else if (hated_q.size() > 0) v = hated_q[$];
          else if (loved_q.size() > 0) v = loved_q[0];
          else got = 1'b0;
          if (!got) res.status = ST_FULL;
          else begin
            if (fr_valid[v]) begin
              if (fr_dirty[v]) begin
                res.writeback_valid = 1'b1;
                res.writeback_page_id = fr_page[v];
              end
              relist(v, LM_NONE);
            end
            fr_valid[v] = 1'b1; fr_page[v] = r.page; fr_pins[v] = 1;
            fr_dirty[v] = 1'b0; fr_hate[v] = 1'b1; fr_list[v] = LM_NONE;
            res.frame_index = FW'(v);
            res.load_needed = 1'b1;
          end
        end
      end
      OP_UNPIN: begin
        if (f < 0 || fr_pins[f] == 0) res.status = ST_UNPIN_ERR;
        else begin
          fr_pins[f]--;
          fr_dirty[f] |= r.dflag;
          fr_hate[f] &= r.hflag;
          if (fr_pins[f] == 0) relist(f, fr_hate[f] ? LM_HATED : LM_LOVED);
          res.frame_index = FW'(f);
        end
      end
      OP_FREE: begin
        if (f < 0 || fr_pins[f] > 0) res.status = ST_FREE_ERR;
        else begin
          relist(f, LM_NONE);
          fr_valid[f] = 1'b0;
          if (free_ptr > f) free_ptr = f;
          res.frame_index = FW'(f);
        end
      end
      default: begin
        if (f < 0) res.status = ST_FLUSH_ERR;
        else begin
          if (fr_dirty[f]) begin
            res.writeback_valid = 1'b1;
            res.writeback_page_id = fr_page[f];
            fr_dirty[f] = 1'b0;
          end
          res.frame_index = FW'(f);
        end
      end
    endcase
    return res;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic bit coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic void queue_req(logic [1:0] op, logic [PAGE_W-1:0] page, bit d, bit h);
    req_t r;
    r.op = op; r.page = page; r.dflag = d; r.hflag = h;
    pending_reqs.push_back(r);
  endfunction

  // Driver: offer pending requests, predict on acceptance
  int tx_gap = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_results.push_back(replace_frame({in_op, in_page_id, in_dirty_flag,
                                                  in_hate_flag}));
        op_seen[in_op]++;
        sent_count++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !hold_tx) begin
          req_t r;
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_op <= r.op; in_page_id <= r.page;
          in_dirty_flag <= r.dflag; in_hate_flag <= r.hflag;
          tx_gap = gap_len();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result beat with the oldest expectation
  int rx_gap = 0;
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        result_t e;
        got_count++;
        if (expected_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("ERROR: result beat with nothing expected");
        end else begin
          e = expected_results.pop_front();
          if (out_status !== e.status || out_frame_index !== e.frame_index ||
              out_load_needed !== e.load_needed ||
              out_writeback_valid !== e.writeback_valid ||
              out_writeback_page_id !== e.writeback_page_id) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("ERROR: exp st=%0d fr=%0d ld=%0b wb=%0b wbp=%h %s",
                       e.status, e.frame_index, e.load_needed, e.writeback_valid,
                       e.writeback_page_id,
                       $sformatf("got st=%0d fr=%0d ld=%0b wb=%0b wbp=%h",
                                 out_status, out_frame_index, out_load_needed,
                                 out_writeback_valid, out_writeback_page_id));
          end
        end
      end
      if (hold_rx) out_stall <= 1'b1;
      else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (out_valid && !out_stall) rx_gap = gap_len();
      end
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("love_hate_buffer_frame_replacer_top test failed");
      $finish;
    end
  end

  function automatic logic [PAGE_W-1:0] rand_page(int pool);
    if ($urandom_range(0, 19) == 0) return PAGE_W'($urandom());
    return PAGE_W'($urandom_range(0, pool - 1));
  endfunction

  initial begin
    int pool;
    logic [PAGE_W-1:0] p;
    idle_cycles = 0;
    free_ptr = 0;
    foreach (fr_valid[i]) begin fr_valid[i] = 1'b0; fr_list[i] = LM_NONE; end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extreme pages, errors on an empty pool, dirty flush, love beats hate
    queue_req(OP_UNPIN, 31'h7FFFFFFF, 1'b1, 1'b1);
    queue_req(OP_FREE, 31'd0, 1'b0, 1'b0);
    queue_req(OP_FLUSH, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_PIN, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_PIN, 31'd0, 1'b0, 1'b0);
    queue_req(OP_PIN, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_FREE, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_UNPIN, 31'h7FFFFFFF, 1'b1, 1'b0);
    queue_req(OP_UNPIN, 31'h7FFFFFFF, 1'b0, 1'b1);
    queue_req(OP_UNPIN, 31'h7FFFFFFF, 1'b0, 1'b1);
    queue_req(OP_FLUSH, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_FLUSH, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_UNPIN, 31'd0, 1'b1, 1'b1);
    queue_req(OP_PIN, 31'd0, 1'b0, 1'b0);
    queue_req(OP_UNPIN, 31'd0, 1'b1, 1'b1);
    queue_req(OP_FREE, 31'd0, 1'b0, 1'b0);
    queue_req(OP_FREE, 31'h7FFFFFFF, 1'b0, 1'b0);
    queue_req(OP_PIN, 31'h2AAAAAAA, 1'b0, 1'b0);
    queue_req(OP_PIN, 31'h55555555, 1'b0, 1'b0);
    queue_req(OP_UNPIN, 31'h55555555, 1'b1, 1'b1);
    queue_req(OP_FLUSH, 31'h2AAAAAAA, 1'b0, 1'b0);

    // Fill every frame, then ask for more: buffer full
    for (int i = 0; i < NUM_FRAMES + 3; i++) queue_req(OP_PIN, PAGE_W'(1000 + i), 1'b0, 1'b0);
    // Release with mixed love/hate and dirty, then evict through both lists
    for (int i = 0; i < NUM_FRAMES; i++)
      queue_req(OP_UNPIN, PAGE_W'(1000 + i), coin(), i % 3 != 0);
    for (int i = 0; i < NUM_FRAMES + 4; i++) queue_req(OP_PIN, PAGE_W'(5000 + i), 1'b0, 1'b0);

    // Pressure: long receiver hold while the sender keeps offering
    hold_rx = 1'b1;
    repeat (400) @(posedge clk);
    hold_rx = 1'b0;

    // Sender pause until all expectations have arrived
    wait (pending_reqs.size() == 0);
    hold_tx = 1'b1;
    wait (expected_results.size() == 0 && !in_valid);
    hold_tx = 1'b0;

    // Random: mostly pin and unpin requests over a modest page pool
    for (int i = 0; i < 430; i++) begin
      pool = (i < 260) ? 96 : 40;
      p = rand_page(pool);
      case ($urandom_range(0, 9))
        0, 1, 2, 3: queue_req(OP_PIN, p, coin(), coin());
        4, 5, 6:    queue_req(OP_UNPIN, p, coin(), coin());
        7, 8:       queue_req(OP_FLUSH, p, coin(), coin());
        default:    queue_req(OP_FREE, p, coin(), coin());
      endcase
    end

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_results.size() == 0);
    repeat (300) @(posedge clk);

    $display("Covered %0d requests (pin %0d, unpin %0d, free %0d, flush %0d),",
             sent_count, op_seen[0], op_seen[1], op_seen[2], op_seen[3]);
    $display("including a full pool and evictions from both lists; %0d results checked.",
             got_count);
    if (mismatch_count == 0 && expected_results.size() == 0)
      $display("love_hate_buffer_frame_replacer_top test passed");
    else
      $display("love_hate_buffer_frame_replacer_top test failed");
    $finish;
  end
endmodule

[files.f]
design/lhbfr_pkg.sv
design/lhbfr_list.sv
design/love_hate_buffer_frame_replacer_top.sv
sim/testbench.sv
